// ===== hw/rtl/sfrc_pkg.sv =====
// Shared constants and types of the serial frame receiver.
`default_nettype none
package sfrc_pkg;

	// Frame limits and field widths
	localparam int MAX_PAYLOAD = 64;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = 7;
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 2;

	// Input word kinds
	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;

	// Register map (index is paddr[2])
	localparam logic REG_START_MARKER = 1'b0;

	// Payload store write port, front to back
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	// Burst request pushed into the queue after a good checksum
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
	} burst_t;

	// Back-end status seen by the front end
	typedef struct packed {
		logic queued;
		logic busy;
	} back_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfrc_ifs.sv =====
// Valid/ready channel interfaces for input words and payload results.
`default_nettype none
interface sfrc_req_if;
	logic                              valid;
	logic                              ready;
	logic [sfrc_pkg::KIND_W-1:0]       kind;
	logic [sfrc_pkg::BYTE_W-1:0]       rx_byte;

	modport source (output valid, kind, rx_byte, input ready);
	modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface sfrc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sfrc_pkg::BYTE_W-1:0]       payload_byte;
	logic [sfrc_pkg::LEN_W-1:0]        frame_length;
	logic                              last;

	modport source (output valid, payload_byte, frame_length, last, input ready);
	modport sink   (input valid, payload_byte, frame_length, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sfrc_front.sv =====
// Front end: accepts input words, runs the frame parser, fills the payload store.
`default_nettype none
module sfrc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [sfrc_pkg::BYTE_W-1:0] start_marker,
	sfrc_req_if.sink                        req,
	input  wire sfrc_pkg::back_stat_t       stat,
	output sfrc_pkg::store_wr_t             wr,
	output sfrc_pkg::burst_t                push
);
	import sfrc_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_PAYLOAD);

	logic [1:0]        phase_q;
	logic [LEN_W-1:0]  fill_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic [BYTE_W-1:0] sum_q;
	logic              rx_on_q;

	logic              is_byte;
	logic              touches_store;
	logic              take;
	logic [LEN_W-1:0]  fill_nxt;
	logic [BYTE_W-1:0] sum_nxt;

	// A byte in payload or checksum phase waits until the previous burst drained
	assign is_byte       = (req.kind == KIND_BYTE) && rx_on_q;
	assign touches_store = is_byte && ((phase_q == PH_DATA) || (phase_q == PH_SUM));
	assign req.ready     = !(touches_store && (stat.queued || stat.busy));
	assign take          = req.valid && req.ready && is_byte;

	assign fill_nxt = fill_q + LEN_W'(1);
	assign sum_nxt  = sum_q + req.rx_byte;

	// Store write and burst push
	always_comb begin
		wr.en      = take && (phase_q == PH_DATA);
		wr.addr    = fill_q[IDX_W-1:0];
		wr.data    = req.rx_byte;
		push.valid = take && (phase_q == PH_SUM) && (sum_nxt == '0);
		push.len   = exp_len_q;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			fill_q    <= '0;
			exp_len_q <= '0;
			sum_q     <= '0;
			rx_on_q   <= 1'b1;
		end else if (req.valid && req.ready) begin
			if (req.kind == KIND_ENABLE) begin
				rx_on_q <= 1'b1;
			end else if (req.kind == KIND_DISABLE) begin
				rx_on_q <= 1'b0;
			end else if (take) begin
				case (phase_q)
					PH_IDLE: begin
						if (req.rx_byte == start_marker) begin
							phase_q <= PH_LEN;
							sum_q   <= '0;
							fill_q  <= '0;
						end
					end
					PH_LEN: begin
						exp_len_q <= req.rx_byte[LEN_W-1:0];
						if ((req.rx_byte == '0) || (req.rx_byte > MAX_LEN_B)) begin
							phase_q <= PH_IDLE;
						end else begin
							phase_q <= PH_DATA;
						end
					end
					PH_DATA: begin
						fill_q <= fill_nxt;
						sum_q  <= sum_nxt;
						if (fill_nxt >= exp_len_q) begin
							phase_q <= PH_SUM;
						end
					end
					PH_SUM: begin
						sum_q   <= sum_nxt;
						phase_q <= PH_IDLE;
						if (sum_nxt == '0) begin
							rx_on_q <= 1'b0;
						end
					end
					default: phase_q <= PH_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sfrc_back.sv =====
// Back end: burst queue, payload store and the result emitter.
`default_nettype none
module sfrc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfrc_pkg::store_wr_t  wr,
	input  wire sfrc_pkg::burst_t     push,
	output sfrc_pkg::back_stat_t      stat,
	sfrc_rsp_if.source                rsp
);
	import sfrc_pkg::*;

	logic [BYTE_W-1:0] store_q [MAX_PAYLOAD];

	// One-entry burst queue
	logic             q_valid_q;
	logic [LEN_W-1:0] q_len_q;

	// Walker
	logic             busy_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;

	// Read stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              last_s1;

	// Output register
	logic              out_v_q;
	logic [BYTE_W-1:0] out_data_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	logic move;
	logic issue;
	logic load;
	logic last_issue;

	assign move       = valid_s1 && (!out_v_q || rsp.ready);
	assign issue      = busy_q && (!valid_s1 || move);
	assign load       = !busy_q && q_valid_q;
	assign last_issue = ((idx_q + LEN_W'(1)) == len_q);

	assign stat.queued = q_valid_q;
	assign stat.busy   = busy_q;

	assign rsp.valid        = out_v_q;
	assign rsp.payload_byte = out_data_q;
	assign rsp.frame_length = out_len_q;
	assign rsp.last         = out_last_q;

	// Payload store (written by the parser, read by the walker) and the data of queue and stages
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
		if (issue) begin
			data_s1 <= store_q[idx_q[IDX_W-1:0]];
			len_s1  <= len_q;
			last_s1 <= last_issue;
		end
		if (move) begin
			out_data_q <= data_s1;
			out_len_q  <= len_s1;
			out_last_q <= last_s1;
		end
		if (push.valid) begin
			q_len_q <= push.len;
		end
		if (load) begin
			len_q <= q_len_q;
		end
	end

	// Control: queue, walker and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_q <= 1'b0;
			busy_q    <= 1'b0;
			idx_q     <= '0;
			valid_s1  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (push.valid) begin
				q_valid_q <= 1'b1;
			end else if (load) begin
				q_valid_q <= 1'b0;
			end

			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + LEN_W'(1);
				if (last_issue) begin
					busy_q <= 1'b0;
				end
			end

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end

			if (move) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_frame_receiver_checksum.sv =====
// Top level of the serial frame receiver: register port, parser and result emitter.
//
//  channel   dir   handshake      word contents
//  req       in    valid/ready    kind, rx_byte
//  rsp       out   valid/ready    payload_byte, frame_length, last
//  apb       in    psel/penable   start_marker at byte address 0
//
// A byte in payload or checksum phase waits while an earlier frame's burst is still
// queued or being read from the store; other input words find req.ready high.
// A good frame's first word passes the burst queue, walker, store read stage and
// output register; then one word per cycle while rsp.ready is high; the single read
// port of the payload store sets this pace. The output register holds a word while
// rsp.ready is low; the parser takes words meanwhile, payload and checksum bytes
// once no burst is pending. arst_n clears all control state; store needs no clear.
`default_nettype none
module serial_frame_receiver_checksum (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfrc_req_if.sink         req,
	sfrc_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfrc_pkg::*;

	logic [BYTE_W-1:0] start_marker_q;
	store_wr_t         wr;
	burst_t            push;
	back_stat_t        stat;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_START_MARKER) ? {24'd0, start_marker_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_START_MARKER)) begin
			start_marker_q <= pwdata[BYTE_W-1:0];
		end
	end

	sfrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_marker (start_marker_q),
		.req          (req),
		.stat         (stat),
		.wr           (wr),
		.push         (push)
	);

	sfrc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.push   (push),
		.stat   (stat),
		.rsp    (rsp)
	);

	// A new burst only enters an empty, idle back end
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!stat.queued && !stat.busy))
		else $error("burst pushed while back end occupied");

	// The store is never rewritten while a burst may still read it
	a_store_safe: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (!stat.queued && !stat.busy))
		else $error("payload store written during burst");

	// A queued burst is picked up in the next cycle when the walker is idle
	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.queued && !stat.busy) |=> (stat.busy && !stat.queued))
		else $error("queued burst not started");

	// Emitted lengths stay within the frame limit
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.frame_length != '0) &&
			(rsp.frame_length <= LEN_W'(MAX_PAYLOAD))))
		else $error("frame length out of range");

endmodule
`default_nettype wire

// ===== tb/sv/sfrc_frame_checker.sv =====
// Scoreboard for the serial frame receiver: mirrors the frame parser and checks payload words.
module sfrc_frame_checker
	import sfrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sfrc_req_if         req,
	sfrc_rsp_if         rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending
);

	typedef enum logic [1:0] {
		SEEK_START,
		SEEK_LEN,
		TAKE_PAYLOAD,
		SEEK_CHECKSUM
	} parse_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              last;
	} payload_word_t;

	// Mirror of the parser state
	logic [BYTE_W-1:0] marker;
	parse_phase_t      phase;
	logic [LEN_W-1:0]  fill_cnt;
	logic [LEN_W-1:0]  want_len;
	logic [BYTE_W-1:0] run_sum;
	logic [BYTE_W-1:0] frame_buf [MAX_PAYLOAD];
	logic              rx_on;

	// Payload words owed by the block, oldest first
	payload_word_t payload_due[$];

	// Apply one accepted input word to the mirror; queue the burst of a good frame
	task automatic absorb_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b);
		payload_word_t w;
		int k;
		case (kind)
			KIND_ENABLE: rx_on = 1'b1;
			KIND_DISABLE: rx_on = 1'b0;
			KIND_BYTE: begin
				if (rx_on) begin
					case (phase)
						SEEK_START: begin
							if (b == marker) begin
								phase = SEEK_LEN;
								run_sum = '0;
								fill_cnt = '0;
							end
						end
						SEEK_LEN: begin
							// out-of-range lengths drop back to idle
							want_len = b[LEN_W-1:0];
							if (b == 0 || b > MAX_PAYLOAD)
								phase = SEEK_START;
							else
								phase = TAKE_PAYLOAD;
						end
						TAKE_PAYLOAD: begin
							frame_buf[fill_cnt[IDX_W-1:0]] = b;
							fill_cnt = fill_cnt + 1'b1;
							run_sum = run_sum + b;
							if (fill_cnt >= want_len)
								phase = SEEK_CHECKSUM;
						end
						default: begin
							run_sum = run_sum + b;
							if (run_sum == 0) begin
								rx_on = 1'b0;
								for (k = 0; k < want_len && k < MAX_PAYLOAD; k++) begin
									w.data = frame_buf[k];
									w.len  = want_len;
									w.last = (k + 1 == want_len);
									payload_due.push_back(w);
								end
							end
							phase = SEEK_START;
						end
					endcase
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		payload_word_t want;
		if (!arst_n) begin
			marker = '0;
			phase = SEEK_START;
			fill_cnt = '0;
			want_len = '0;
			run_sum = '0;
			rx_on = 1'b1;
			payload_due.delete();
			errors = 0;
		end else begin
			// register write; only the start marker index is mapped
			if (psel && penable && pwrite && pready && paddr[2] == REG_START_MARKER)
				marker = pwdata[BYTE_W-1:0];

			if (req.valid && req.ready)
				absorb_word(req.kind, req.rx_byte);

			// compare each accepted payload word with the oldest one owed
			if (rsp.valid && rsp.ready) begin
				if (payload_due.size() == 0) begin
					$error("unexpected payload word: payload_byte %0h frame_length %0d last %0b",
						rsp.payload_byte, rsp.frame_length, rsp.last);
					errors++;
				end else begin
					want = payload_due.pop_front();
					if (rsp.payload_byte !== want.data) begin
						$error("payload_byte: expected %0h, got %0h", want.data, rsp.payload_byte);
						errors++;
					end
					if (rsp.frame_length !== want.len) begin
						$error("frame_length: expected %0d, got %0d", want.len, rsp.frame_length);
						errors++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, rsp.last);
						errors++;
					end
				end
			end
		end
		pending = payload_due.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the serial frame receiver: clock, reset, stimulus and verdict.
module tb;
	import sfrc_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          LONG_HOLD     = 400;
	localparam int          SETTLE_CYCLES = 8;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [2:0]  ADDR_MARKER   = {REG_START_MARKER, 2'b00};
	localparam logic [2:0]  ADDR_SPARE    = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          results_due;
	int unsigned cycles = 0;
	int          words_sent = 0;
	bit          idle_on = 1'b1;
	bit          hold_rsp = 1'b0;
	logic [BYTE_W-1:0] marker_now = '0;

	sfrc_req_if req_ch ();
	sfrc_rsp_if rsp_ch ();

	serial_frame_receiver_checksum dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sfrc_frame_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (mismatches),
		.pending (results_due)
	);

	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[serial_frame_receiver_checksum] ERROR");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one word and hold it until accepted; returns at a falling edge
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.kind    <= kind;
		req_ch.rx_byte <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		if (kind != KIND_UNUSED)
			words_sent++;
	endtask

	// Full frame, random payload, marker inside now and then; bad_sum spoils checksum
	task automatic send_frame(input int len, input bit bad_sum);
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] b;
		acc = '0;
		send_word(KIND_BYTE, marker_now);
		send_word(KIND_BYTE, 8'(len));
		repeat (len) begin
			b = ($urandom_range(0, 7) == 0) ? marker_now : 8'($urandom);
			acc = acc + b;
			send_word(KIND_BYTE, b);
		end
		b = -acc;
		if (bad_sum)
			b = b ^ 8'($urandom_range(1, 255));
		send_word(KIND_BYTE, b);
	endtask

	// Mostly short frames, sometimes medium, rarely the full store
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(9, 40);
		else if (r < 98)
			return $urandom_range(41, MAX_PAYLOAD - 1);
		else
			return MAX_PAYLOAD;
	endfunction

	// APB write: setup then access cycle
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_marker(input logic [BYTE_W-1:0] value);
		reg_write(ADDR_MARKER, {24'($urandom), value});
		marker_now = value;
	endtask

	// Stop offering and wait until every owed payload word has come out
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random traffic: mostly well-formed frames, some noise and broken frames
	task automatic random_mix(input int target);
		int r;
		int len;
		int cut;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if ($urandom_range(0, 9) != 0)
					send_word(KIND_ENABLE, 8'($urandom));
				send_frame(pick_len(), $urandom_range(0, 9) == 0);
			end else if (r < 80) begin
				repeat ($urandom_range(1, 4))
					send_word(2'($urandom), 8'($urandom));
			end else if (r < 88) begin
				// bad length: zero or above the store size
				send_word(KIND_ENABLE, 8'($urandom));
				send_word(KIND_BYTE, marker_now);
				if ($urandom_range(0, 1) == 0)
					send_word(KIND_BYTE, 8'd0);
				else
					send_word(KIND_BYTE, 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
			end else if (r < 94) begin
				// truncated frame, then bytes while the receiver is off
				len = $urandom_range(1, 8);
				cut = $urandom_range(0, len - 1);
				send_word(KIND_BYTE, marker_now);
				send_word(KIND_BYTE, 8'(len));
				repeat (cut) send_word(KIND_BYTE, 8'($urandom));
				send_word(KIND_DISABLE, 8'($urandom));
				repeat ($urandom_range(1, 3)) send_word(KIND_BYTE, 8'($urandom));
				send_word(KIND_ENABLE, 8'($urandom));
			end else begin
				send_word(KIND_DISABLE, 8'($urandom));
				repeat ($urandom_range(1, 4)) send_word(KIND_BYTE, 8'($urandom));
				send_word(KIND_ENABLE, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.kind    = KIND_BYTE;
		req_ch.rx_byte = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, marker at its reset value of zero
		send_word(KIND_UNUSED, 8'h00);          // unused kind, would open a frame otherwise
		send_word(KIND_BYTE, 8'h00);            // one-byte frame, payload 0xFF
		send_word(KIND_BYTE, 8'd1);
		send_word(KIND_BYTE, 8'hFF);
		send_word(KIND_BYTE, 8'h01);
		send_word(KIND_BYTE, 8'h00);            // receiver off after a good frame
		send_word(KIND_ENABLE, 8'hFF);
		send_word(KIND_BYTE, 8'h00);            // zero length
		send_word(KIND_BYTE, 8'd0);
		send_word(KIND_BYTE, 8'h00);            // one above the store size
		send_word(KIND_BYTE, 8'(MAX_PAYLOAD + 1));
		send_word(KIND_BYTE, 8'h00);            // largest length byte
		send_word(KIND_BYTE, 8'hFF);
		send_word(KIND_BYTE, 8'h00);            // disable and enable mid-frame
		send_word(KIND_DISABLE, 8'h00);
		send_word(KIND_BYTE, 8'h55);
		send_word(KIND_ENABLE, 8'h00);
		send_word(KIND_BYTE, 8'd2);
		send_word(KIND_BYTE, 8'h00);            // marker inside the payload
		send_word(KIND_BYTE, 8'h80);
		send_word(KIND_BYTE, 8'h00);            // bad checksum, dropped
		send_word(KIND_BYTE, 8'h00);            // good frame carrying the marker
		send_word(KIND_BYTE, 8'd2);
		send_word(KIND_BYTE, 8'h00);
		send_word(KIND_BYTE, 8'h01);
		send_word(KIND_BYTE, 8'hFF);
		drain_results();

		// Unmapped index is ignored; then the top marker value
		reg_write(ADDR_SPARE, 32'hFFFF_FFA5);
		set_marker(8'hFF);
		random_mix(150);
		drain_results();

		// Long result stall: full-size burst held while the next frame backs up
		set_marker(8'h7E);
		hold_rsp = 1'b1;
		send_word(KIND_ENABLE, 8'h00);
		send_frame(MAX_PAYLOAD, 1'b0);
		send_word(KIND_ENABLE, 8'h00);
		send_frame(12, 1'b0);
		random_mix(300);
		drain_results();

		set_marker(8'($urandom));
		random_mix(380);
		drain_results();

		// Closing stretch without idling on either side
		set_marker(8'h00);
		idle_on = 1'b0;
		random_mix(460);
		drain_results();
		repeat (20) @(negedge clk);

		if (mismatches == 0)
			$display("[serial_frame_receiver_checksum] OK");
		else
			$display("[serial_frame_receiver_checksum] ERROR");
		$finish;
	end

endmodule
